// File: rtl/pwed_pkg.sv
// Shared widths, codes and reset values for the pairwise distance core.
`default_nettype none
package pwed_pkg;

  // Word field widths
  localparam int CMD_W     = 1;
  localparam int ROW_IN_W  = 6;
  localparam int COL_IN_W  = 4;
  localparam int VAL_W     = 16;
  localparam int DIST_W    = 26;

  // Configuration registers
  localparam int ROW_CNT_W  = 7;
  localparam int COL_CNT_W  = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RST = 7'd64;
  localparam logic [COL_CNT_W-1:0] COL_COUNT_RST = 5'd16;

  typedef enum logic {
    REG_ROW_COUNT    = 1'b0,
    REG_COLUMN_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // Defaults for the core parameters
  localparam int MAX_ROWS_DEF    = 64;
  localparam int MAX_COLS_DEF    = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  // Sum of squares saturates at 2^36
  localparam int SUM_W = 37;
  localparam logic [SUM_W-1:0] SUM_CAP = {1'b1, {(SUM_W-1){1'b0}}};
  localparam int SQ_EXT_W = 66;

  // Square root of sum * 2^16: 52-bit radicand, one result bit per step
  localparam int X_W        = 52;
  localparam int SQRT_STEPS = 26;
  localparam int STEP_W     = 5;
  localparam int REM_W      = 29;

endpackage
`default_nettype wire

// File: rtl/pwed_if.sv
// Word channels of the pairwise distance core: input words and result words.
`default_nettype none
interface pwed_in_if;
  logic                                valid;
  logic                                ready;
  logic [pwed_pkg::CMD_W-1:0]          cmd;
  logic [pwed_pkg::ROW_IN_W-1:0]       first_row;
  logic [pwed_pkg::ROW_IN_W-1:0]       second_row;
  logic [pwed_pkg::COL_IN_W-1:0]       column;
  logic signed [pwed_pkg::VAL_W-1:0]   value;

  modport source (output valid, cmd, first_row, second_row, column, value, input ready);
  modport sink   (input valid, cmd, first_row, second_row, column, value, output ready);
endinterface

interface pwed_out_if;
  logic                          valid;
  logic                          ready;
  logic [pwed_pkg::DIST_W-1:0]   distance;
  logic                          bad_row;

  modport source (output valid, distance, bad_row, input ready);
  modport sink   (input valid, distance, bad_row, output ready);
endinterface
`default_nettype wire

// File: rtl/pairwise_euclidean_distance_core.sv
// Pairwise Euclidean distance core: sample memory, squared-difference pipe, bit-serial sqrt.
//
//  port    | dir | handshake          | word
//  --------+-----+--------------------+------------------------------------------
//  in_ch   | in  | valid/ready        | cmd, first_row, second_row, column, value
//  out_ch  | out | valid/ready        | distance, bad_row (one per query)
//  cfg_*   | in  | APB, pready tied 1 | row_count @0x0, column_count @0x4
//
// A load word is written through the single memory write port.
// A query streams column pairs through the two memory read ports and the
// square/accumulate pipe, then runs the restoring square root unless the sum
// saturated, then moves the result to the output register. A bad-row query goes
// straight to the output register. Synchronous active-low reset clears control
// and config; the sample memory is not cleared. A stalled output word sits in
// the output register while the next input word is taken.
`default_nettype none
module pairwise_euclidean_distance_core #(
  parameter int MAX_ROWS    = pwed_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS    = pwed_pkg::MAX_COLS_DEF,
  parameter int SAMPLE_BITS = pwed_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  pwed_in_if.sink                                in_ch,
  pwed_out_if.source                             out_ch,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [pwed_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [pwed_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic      [pwed_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                                   cfg_pready
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int NC_W   = $clog2(MAX_COLS + 1);
  localparam int D_W    = SAMPLE_BITS + 1;
  localparam int SQ_W   = 2 * D_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SUM,
    S_SQRT,
    S_DONE
  } state_t;

  // Configuration registers
  logic [pwed_pkg::ROW_CNT_W-1:0] row_count_r;
  logic [pwed_pkg::COL_CNT_W-1:0] col_count_r;
  logic                           cfg_we;

  // Control and datapath state
  state_t                           state_r;
  logic [pwed_pkg::ROW_IN_W-1:0]    row_a_r;
  logic [pwed_pkg::ROW_IN_W-1:0]    row_b_r;
  logic [NC_W-1:0]                  k_r;
  logic [NC_W-1:0]                  ncols_r;
  logic                             v_rd_r;
  logic                             v_d_r;
  logic                             v_sq_r;
  logic [pwed_pkg::SUM_W-1:0]       sum_r;
  logic [pwed_pkg::X_W-1:0]         x_r;
  logic [pwed_pkg::REM_W-1:0]       rem_r;
  logic [pwed_pkg::DIST_W-1:0]      root_r;
  logic [pwed_pkg::STEP_W-1:0]      step_r;
  logic [pwed_pkg::DIST_W-1:0]      res_dist_r;
  logic                             res_bad_r;
  logic                             out_valid_r;
  logic [pwed_pkg::DIST_W-1:0]      out_dist_r;
  logic                             out_bad_r;

  // Sample memory and read pipe
  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [SAMPLE_BITS-1:0] rd_a_r;
  logic [SAMPLE_BITS-1:0] rd_b_r;
  logic [D_W-1:0]         diff_r;
  logic [SQ_W-1:0]        sq_r;

  logic                       in_fire;
  logic                       is_query;
  logic                       load_ok;
  logic                       bad_in;
  logic [ADDR_W-1:0]          waddr;
  logic signed [31:0]         val_ext;
  logic [SAMPLE_BITS-1:0]     wdata;
  logic [6:0]                 cc_ext;
  logic [NC_W-1:0]            ncols_in;
  logic                       issue;
  logic [ADDR_W-1:0]          raddr_a;
  logic [ADDR_W-1:0]          raddr_b;
  logic signed [D_W-1:0]      diff;
  logic [pwed_pkg::SQ_EXT_W-1:0] sq_ext;
  logic [pwed_pkg::SUM_W-1:0] sq_sat;
  logic [pwed_pkg::SUM_W:0]   acc;
  logic [pwed_pkg::SUM_W-1:0] sum_nxt;
  logic                       pipe_empty;
  logic [pwed_pkg::REM_W-1:0] cand;
  logic [pwed_pkg::REM_W-1:0] trial;
  logic                       ge;
  logic [pwed_pkg::DIST_W-1:0] root_nxt;
  logic                       out_load;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= pwed_pkg::ROW_COUNT_RST;
      col_count_r <= pwed_pkg::COL_COUNT_RST;
    end else if (cfg_we) begin
      unique case (pwed_pkg::reg_idx_t'(cfg_paddr[2]))
        pwed_pkg::REG_ROW_COUNT:    row_count_r <= cfg_pwdata[pwed_pkg::ROW_CNT_W-1:0];
        pwed_pkg::REG_COLUMN_COUNT: col_count_r <= cfg_pwdata[pwed_pkg::COL_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (pwed_pkg::reg_idx_t'(cfg_paddr[2]))
      pwed_pkg::REG_ROW_COUNT:    cfg_prdata = pwed_pkg::CFG_DATA_W'(row_count_r);
      pwed_pkg::REG_COLUMN_COUNT: cfg_prdata = pwed_pkg::CFG_DATA_W'(col_count_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  // ---------------- input decode ----------------
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_query    = (pwed_pkg::cmd_t'(in_ch.cmd) == pwed_pkg::CMD_QUERY);

  always_comb begin
    load_ok  = (32'(in_ch.first_row) < 32'(MAX_ROWS)) && (32'(in_ch.column) < 32'(MAX_COLS));
    waddr    = ADDR_W'(32'(in_ch.first_row) * MAX_COLS + 32'(in_ch.column));
    val_ext  = 32'(in_ch.value);
    wdata    = val_ext[SAMPLE_BITS-1:0];
    bad_in   = (7'(in_ch.first_row) >= row_count_r) || (7'(in_ch.second_row) >= row_count_r)
            || (32'(in_ch.first_row) >= 32'(MAX_ROWS))
            || (32'(in_ch.second_row) >= 32'(MAX_ROWS));
    cc_ext   = 7'(col_count_r);
    ncols_in = (32'(cc_ext) < 32'(MAX_COLS)) ? NC_W'(cc_ext) : NC_W'(MAX_COLS);
  end

  // ---------------- sample memory ----------------
  assign issue   = (state_r == S_SUM) && (k_r < ncols_r);
  assign raddr_a = ADDR_W'(32'(row_a_r) * MAX_COLS + 32'(k_r));
  assign raddr_b = ADDR_W'(32'(row_b_r) * MAX_COLS + 32'(k_r));

  always_ff @(posedge clk) begin
    if (in_fire && !is_query && load_ok) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[raddr_b];
  end

  // ---------------- square / accumulate pipe ----------------
  assign diff = $signed({rd_a_r[SAMPLE_BITS-1], rd_a_r}) - $signed({rd_b_r[SAMPLE_BITS-1], rd_b_r});

  always_ff @(posedge clk) begin
    diff_r <= diff[D_W-1] ? D_W'(-diff) : D_W'(diff);
    sq_r   <= diff_r * diff_r;
  end

  always_comb begin
    sq_ext = pwed_pkg::SQ_EXT_W'(sq_r);
    if (sq_ext >= pwed_pkg::SQ_EXT_W'(pwed_pkg::SUM_CAP)) begin
      sq_sat = pwed_pkg::SUM_CAP;
    end else begin
      sq_sat = sq_ext[pwed_pkg::SUM_W-1:0];
    end
    acc = {1'b0, sum_r} + {1'b0, sq_sat};
    sum_nxt = (acc >= {1'b0, pwed_pkg::SUM_CAP}) ? pwed_pkg::SUM_CAP
                                                  : acc[pwed_pkg::SUM_W-1:0];
    pipe_empty = !v_rd_r && !v_d_r && !v_sq_r;
  end

  // ---------------- restoring square root step ----------------
  always_comb begin
    cand     = {rem_r[pwed_pkg::REM_W-3:0], x_r[pwed_pkg::X_W-1 -: 2]};
    trial    = pwed_pkg::REM_W'({root_r, 2'b01});
    ge       = (cand >= trial);
    root_nxt = {root_r[pwed_pkg::DIST_W-2:0], ge};
  end

  // result moves to the output register when that register is free or draining
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_a_r     <= '0;
      row_b_r     <= '0;
      k_r         <= '0;
      ncols_r     <= '0;
      v_rd_r      <= 1'b0;
      v_d_r       <= 1'b0;
      v_sq_r      <= 1'b0;
      sum_r       <= '0;
      x_r         <= '0;
      rem_r       <= '0;
      root_r      <= '0;
      step_r      <= '0;
      res_dist_r  <= '0;
      res_bad_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_dist_r  <= '0;
      out_bad_r   <= 1'b0;
    end else begin
      v_rd_r <= issue;
      v_d_r  <= v_rd_r;
      v_sq_r <= v_d_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_dist_r  <= res_dist_r;
        out_bad_r   <= res_bad_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire && is_query) begin
            if (bad_in) begin
              res_dist_r <= '0;
              res_bad_r  <= 1'b1;
              state_r    <= S_DONE;
            end else begin
              row_a_r <= in_ch.first_row;
              row_b_r <= in_ch.second_row;
              k_r     <= '0;
              ncols_r <= ncols_in;
              sum_r   <= '0;
              state_r <= S_SUM;
            end
          end
        end
        S_SUM: begin
          if (issue) begin
            k_r <= k_r + NC_W'(1);
          end
          if (v_sq_r) begin
            sum_r <= sum_nxt;
          end
          if (!issue && pipe_empty) begin
            if (sum_r == pwed_pkg::SUM_CAP) begin
              res_dist_r <= '1;
              res_bad_r  <= 1'b0;
              state_r    <= S_DONE;
            end else begin
              // radicand is sum * 2^16 so the root carries 8 fraction bits
              x_r     <= {sum_r[pwed_pkg::SUM_W-2:0], 16'b0};
              rem_r   <= '0;
              root_r  <= '0;
              step_r  <= pwed_pkg::STEP_W'(pwed_pkg::SQRT_STEPS);
              state_r <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          rem_r  <= ge ? (cand - trial) : cand;
          root_r <= root_nxt;
          x_r    <= {x_r[pwed_pkg::X_W-3:0], 2'b00};
          step_r <= step_r - pwed_pkg::STEP_W'(1);
          if (step_r == pwed_pkg::STEP_W'(1)) begin
            res_dist_r <= root_nxt;
            res_bad_r  <= 1'b0;
            state_r    <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.distance = out_dist_r;
  assign out_ch.bad_row  = out_bad_r;

endmodule
`default_nettype wire
